// ----- design/pck_rle_sprite_decoder_core_defines.svh -----
// Assertion macros shared by the checker of the sprite decoder.
`ifndef PCK_RLE_SPRITE_DECODER_CORE_DEFINES_SVH
`define PCK_RLE_SPRITE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PRSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite decoder check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite decoder check failed");

`endif

// ----- design/prsd_pkg.sv -----
package prsd_pkg;

	// Width of the internal pixel position; it saturates at all ones.
	localparam int PosBits   = 20;
	localparam int ByteBits  = 8;
	localparam int WidthBits = 11;
	localparam int StartBits = 20;
	localparam int RunBits   = 18;
	localparam int ColorBits = 8;
	localparam int SumBits   = ((PosBits > RunBits) ? PosBits : RunBits) + 1;
	localparam int OutDataBits = ((StartBits + RunBits + ColorBits + 7) / 8) * 8;

	localparam logic [ByteBits-1:0]  CodeSkip   = 8'd254;
	localparam logic [ByteBits-1:0]  CodeEnd    = 8'd255;
	localparam logic [WidthBits-1:0] WidthMax   = 11'd1024;
	localparam logic [WidthBits-1:0] WidthReset = 11'd32;

	typedef enum logic [2:0] {
		PH_ROWS = 3'b001,
		PH_BODY = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	typedef struct packed {
		logic                 emit;
		logic [StartBits-1:0] start_pos;
		logic [RunBits-1:0]   run_length;
		logic [ColorBits-1:0] color;
		logic                 frame_end;
		phase_t               next_phase;
		logic [PosBits-1:0]   next_pos;
	} step_t;

endpackage

// ----- design/prsd_step.sv -----
// Decodes one byte against the current phase and position.
module prsd_step import prsd_pkg::*; (
	input  logic [ByteBits-1:0]  data_byte,
	input  phase_t               phase,
	input  logic [PosBits-1:0]   pos,
	input  logic [WidthBits-1:0] frame_width,
	output step_t                step
);

	localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

	logic [WidthBits-1:0]           width_clamped;
	logic [ByteBits+WidthBits-1:0]  blank_product;
	logic [RunBits-1:0]             len;
	logic                           is_run;
	logic [SumBits-1:0]             pos_sum;
	logic [StartBits+PosBits-1:0]   pos_ext;

	assign width_clamped = (frame_width > WidthMax) ? WidthMax : frame_width;
	assign blank_product = ByteBits'(data_byte) * width_clamped;
	assign pos_sum       = SumBits'(pos) + SumBits'(len);
	assign pos_ext       = {{StartBits{1'b0}}, pos};

	always_comb begin
		step            = '0;
		step.start_pos  = pos_ext[StartBits-1:0];
		step.next_phase = phase;
		step.next_pos   = pos;
		len             = '0;
		is_run          = 1'b0;
		case (phase)
			PH_BODY: begin
				if (data_byte == CodeEnd) begin
					step.emit       = 1'b1;
					step.frame_end  = 1'b1;
					step.next_pos   = '0;
					step.next_phase = PH_ROWS;
				end else if (data_byte == CodeSkip) begin
					step.next_phase = PH_SKIP;
				end else begin
					len        = RunBits'(1);
					step.color = data_byte;
					is_run     = 1'b1;
				end
			end
			PH_SKIP: begin
				step.next_phase = PH_BODY;
				len             = RunBits'(data_byte);
				is_run          = 1'b1;
			end
			default: begin
				step.next_phase = PH_BODY;
				len             = blank_product[RunBits-1:0];
				is_run          = 1'b1;
			end
		endcase
		step.run_length = len;
		if (is_run && (len != '0)) begin
			step.emit = 1'b1;
			// Saturate the position once the run would reach the top.
			if (pos_sum >= SumBits'(PosMax)) begin
				step.next_pos = PosMax;
			end else begin
				step.next_pos = pos_sum[PosBits-1:0];
			end
		end
	end

endmodule

// ----- design/pck_rle_sprite_decoder_core.sv -----
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata[7:0] data_byte
// m_axis    out        tdata: start_pos[19:0], run_length[37:20], color[45:38], zero pad;
//                      tlast: frame_end
// cfg       in         data[10:0] frame_width
//
// One byte is taken in every cycle when the output side keeps up; its run word
// is offered on m_axis after the byte has passed the input register, then the
// result register. The decode of a byte, including the 8 by 11 bit blank-row
// multiply and the saturating position add, sits between those registers.
// arst_n sets the phase to PH_ROWS, clears the position and the valid flags and sets frame_width to 32.
// When m_axis stalls with a word held, the input register can still take one more byte if it is empty.
module pck_rle_sprite_decoder_core import prsd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [ByteBits-1:0]    s_axis_tdata,   // data_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OutDataBits-1:0] m_axis_tdata,   // start_pos, run_length, color, pad
	output logic                   m_axis_tlast,   // frame_end
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [WidthBits-1:0]   cfg_data        // frame_width
);

	logic                 valid_s1;
	logic [ByteBits-1:0]  byte_s1;
	logic                 out_free;
	logic                 fire_s1;
	logic                 out_valid_q;
	logic [StartBits-1:0] start_pos_q;
	logic [RunBits-1:0]   run_length_q;
	logic [ColorBits-1:0] color_q;
	logic                 frame_end_q;
	logic [WidthBits-1:0] frame_width_q;
	phase_t               phase_q;
	logic [PosBits-1:0]   pos_q;
	step_t                step;

	// The result register can load when it is empty or its word is being taken.
	assign out_free      = !out_valid_q || m_axis_tready;
	// A byte in the input register is decoded once the result side can take
	// whatever it produces; bytes that produce nothing still move on.
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= WidthReset;
		end else if (cfg_valid) begin
			frame_width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	prsd_step u_step (
		.data_byte   (byte_s1),
		.phase       (phase_q),
		.pos         (pos_q),
		.frame_width (frame_width_q),
		.step        (step)
	);

	// Decoder state moves only when the byte in the input register is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ROWS;
			pos_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= step.next_phase;
			pos_q   <= step.next_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && step.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && step.emit) begin
			start_pos_q  <= step.start_pos;
			run_length_q <= step.run_length;
			color_q      <= step.color;
			frame_end_q  <= step.frame_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OutDataBits'({color_q, run_length_q, start_pos_q});
	assign m_axis_tlast  = frame_end_q;

endmodule

// ----- design/prsd_checker.sv -----
`include "pck_rle_sprite_decoder_core_defines.svh"

// Watches the ports of the sprite decoder.
module prsd_checker import prsd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OutDataBits-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	logic stalled;
	logic end_clean;
	logic [RunBits-1:0]   run_length;
	logic [ColorBits-1:0] color;

	assign stalled    = m_axis_tvalid && !m_axis_tready;
	assign run_length = m_axis_tdata[StartBits +: RunBits];
	assign color      = m_axis_tdata[StartBits+RunBits +: ColorBits];
	assign end_clean  = (run_length == '0) && (color == '0);

	`PRSD_ASSERT_NEXT(a_out_held, clk, arst_n, stalled, m_axis_tvalid)
	`PRSD_ASSERT_NEXT(a_out_stable, clk, arst_n, stalled, $stable({m_axis_tlast, m_axis_tdata}))
	`PRSD_ASSERT_NOW(a_end_empty, clk, arst_n, m_axis_tvalid && m_axis_tlast, end_clean)
	`PRSD_ASSERT_NOW(a_run_nonzero, clk, arst_n, m_axis_tvalid && !m_axis_tlast, run_length != '0)
	`PRSD_ASSERT_NOW(a_in_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind pck_rle_sprite_decoder_core prsd_checker u_prsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- tb/prsd_run_checker.sv -----
module prsd_run_checker import prsd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [ByteBits-1:0]    s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OutDataBits-1:0] m_axis_tdata,
	input  logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [WidthBits-1:0]   cfg_data,
	output int                     fail_count,
	output int                     pending
);

	localparam int unsigned PosMax = (1 << PosBits) - 1;

	typedef struct packed {
		logic [StartBits-1:0] start_pos;
		logic [RunBits-1:0]   run_length;
		logic [ColorBits-1:0] color;
		logic                 frame_end;
	} pixel_run_t;

	pixel_run_t           expected_runs[$];
	logic [WidthBits-1:0] row_width;
	phase_t               stream_phase;
	logic [PosBits-1:0]   position;
	int                   fails;

	function automatic void queue_run(input int unsigned len,
			input logic [ColorBits-1:0] colour_idx, input logic closes);
		pixel_run_t r;
		r.start_pos  = position[StartBits-1:0];
		r.run_length = len[RunBits-1:0];
		r.color      = colour_idx;
		r.frame_end  = closes;
		expected_runs = {expected_runs, r};
	endfunction

	// Empty runs produce nothing; the position sticks at all ones.
	function automatic void emit_run(input int unsigned len, input logic [ColorBits-1:0] colour_idx);
		int unsigned room;
		if (len != 0) begin
			queue_run(len, colour_idx, 1'b0);
			room = PosMax - position;
			if (len >= room) begin
				position = PosBits'(PosMax);
			end else begin
				position = PosBits'(position + len);
			end
		end
	endfunction

	function automatic void decode_byte(input logic [ByteBits-1:0] b);
		int unsigned w;
		case (stream_phase)
		PH_BODY: begin
			if (b == CodeEnd) begin
				queue_run(0, '0, 1'b1);
				position     = '0;
				stream_phase = PH_ROWS;
			end else if (b == CodeSkip) begin
				stream_phase = PH_SKIP;
			end else begin
				emit_run(1, b);
			end
		end
		PH_SKIP: begin
			stream_phase = PH_BODY;
			emit_run(32'(b), '0);
		end
		default: begin
			stream_phase = PH_BODY;
			w = 32'((row_width > WidthMax) ? WidthMax : row_width);
			emit_run(w * 32'(b), '0);
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_run_t want;
		pixel_run_t got;
		if (!arst_n) begin
			row_width    = WidthReset;
			stream_phase = PH_ROWS;
			position     = '0;
			fails        = 0;
			expected_runs.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				row_width = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.start_pos  = m_axis_tdata[StartBits-1:0];
				got.run_length = m_axis_tdata[StartBits +: RunBits];
				got.color      = m_axis_tdata[StartBits+RunBits +: ColorBits];
				got.frame_end  = m_axis_tlast;
				if (expected_runs.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("unexpected run: start %0d length %0d colour %0d end %0d",
							got.start_pos, got.run_length, got.color, got.frame_end);
					end
				end else begin
					want = expected_runs.pop_front();
					if (got.start_pos !== want.start_pos || got.run_length !== want.run_length ||
							got.color !== want.color || got.frame_end !== want.frame_end) begin
						fails++;
						if (fails <= 10) begin
							$display({"run mismatch (expected/actual): start %0d/%0d ",
								"length %0d/%0d colour %0d/%0d end %0d/%0d"},
								want.start_pos, got.start_pos, want.run_length, got.run_length,
								want.color, got.color, want.frame_end, got.frame_end);
						end
					end
				end
			end
			fail_count <= fails;
			pending    <= expected_runs.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Sprite stream decoder bench: coded bytes go in on s_axis, pixel runs come out on
// m_axis. A checker beside the block keeps its own decoder state and compares every
// run word against its prediction; this module only makes stimulus and gives the verdict.
module testbench;
	import prsd_pkg::*;

	// No handshake for this many cycles means the block has hung.
	localparam int IdleLimit   = 2000;
	// Cycles let pass after the last run word, well beyond what the two-stage pipeline needs to empty.
	localparam int DrainCycles = 8;
	// Cycles let pass before a register write, as a byte may still be in flight
	// inside the block without producing a run.
	localparam int SettleCycles = 4;

	// Receiver stall patterns.
	localparam int RxFree   = 0;
	localparam int RxHalf   = 1;
	localparam int RxSparse = 2;
	localparam int RxStall  = 3;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [ByteBits-1:0]    s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OutDataBits-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [WidthBits-1:0]   cfg_data      = '0;

	int fail_count;
	int pending_runs;
	int sent_items  = 0;
	int burst_left  = 0;
	bit gaps_on     = 1'b1;
	int idle_cycles = 0;
	int rx_mode     = RxFree;
	int rx_left     = 0;
	int stall_left  = 0;

	pck_rle_sprite_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	prsd_run_checker i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending_runs)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver picks a stall pattern for a stretch of cycles, then another.
	// The free-running pattern gives stretches with no back-pressure at all.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RxFree, RxStall);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
		RxFree: begin
			m_axis_tready <= 1'b1;
		end
		RxHalf: begin
			m_axis_tready <= 1'($urandom_range(0, 1));
		end
		RxSparse: begin
			m_axis_tready <= ($urandom_range(0, 3) == 0);
		end
		default: begin
			// Long stalls, each broken by a single ready cycle.
			if (stall_left == 0) begin
				stall_left = $urandom_range(1, 15);
				m_axis_tready <= 1'b1;
			end else begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end
		end
		endcase
	end

	// Watchdog: any accepted word on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Offers one byte and returns at the edge where it was taken. The sender
	// works in bursts; between bursts it drops valid for a random gap when gaps are on. Valid is
	// left high on return so that back-to-back bytes need no second assignment.
	task automatic send_byte(input logic [ByteBits-1:0] b);
		int gap;
		if (burst_left == 0) begin
			if (gaps_on) begin
				gap = $urandom_range(1, 12);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sent_items++;
	endtask

	// Stops the sender and waits until every predicted run has arrived, then
	// waits SettleCycles more for any byte that produced no run but is still in the pipe.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_runs != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_width(input logic [WidthBits-1:0] w);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One frame with random content: a blank-row count, a body of literals and
	// skip pairs with the odd stray byte, and normally the end marker. A stray
	// byte or an unclosed frame knocks the stream out of step, which the
	// decoder must follow just the same.
	task automatic send_frame(input int body_len, input bit closed);
		int                  pick;
		logic [ByteBits-1:0] lead;
		if ($urandom_range(0, 3) == 0) begin
			lead = ByteBits'($urandom_range(0, 3));
		end else begin
			lead = ByteBits'($urandom);
		end
		send_byte(lead);
		repeat (body_len) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				send_byte(ByteBits'($urandom_range(0, 253)));
			end else if (pick < 8) begin
				send_byte(CodeSkip);
				case ($urandom_range(0, 7))
				0: send_byte(8'd0);
				1: send_byte(CodeSkip);
				2: send_byte(CodeEnd);
				default: send_byte(ByteBits'($urandom));
				endcase
			end else if (pick == 8) begin
				send_byte(ByteBits'($urandom));
			end else begin
				send_byte(($urandom_range(0, 1) != 0) ? 8'd253 : 8'd0);
			end
		end
		if (closed) begin
			send_byte(CodeEnd);
		end
	endtask

	initial begin
		int start_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset width of 32. The first starts with no
		// blank rows, so its leading byte gives no run; then extreme literals,
		// an empty skip, and skips of 255 and 254 which must not be taken as
		// control codes.
		send_byte(8'd0);
		send_byte(8'd1);
		send_byte(8'd0);
		send_byte(8'd253);
		send_byte(CodeSkip);
		send_byte(8'd0);
		send_byte(CodeSkip);
		send_byte(CodeEnd);
		send_byte(CodeSkip);
		send_byte(CodeSkip);
		send_byte(CodeEnd);
		// Leading bytes of 255 and 254 are plain blank-row counts; the
		// second frame is closed straight after its leading byte.
		send_byte(CodeEnd);
		send_byte(8'd7);
		send_byte(CodeEnd);
		send_byte(CodeSkip);
		send_byte(CodeEnd);

		// A zero width makes every blank-row run empty.
		write_width('0);
		send_byte(8'd200);
		send_byte(8'd5);
		send_byte(CodeEnd);
		// Widths above 1024 are clipped to 1024.
		write_width('1);
		send_byte(CodeEnd);
		send_byte(CodeEnd);
		write_width(WidthMax);
		send_byte(8'd1);
		send_byte(CodeEnd);
		write_width(11'd1);
		send_byte(8'd3);
		send_byte(CodeEnd);

		// Random frames under several widths, with and without sender gaps.
		for (int p = 0; p < 7; p++) begin
			case (p)
			0: write_width(WidthBits'($urandom_range(1, WidthMax)));
			1: write_width(WidthMax);
			2: write_width(11'd1);
			3: write_width('0);
			4: write_width(WidthBits'($urandom_range(WidthMax + 1, (1 << WidthBits) - 1)));
			5: write_width(WidthBits'($urandom_range(1, 64)));
			default: write_width(WidthBits'($urandom));
			endcase
			gaps_on = (p % 3) != 1;
			start_items = sent_items;
			while (sent_items - start_items < 80) begin
				send_frame($urandom_range(0, 24), $urandom_range(0, 7) != 0);
			end
		end

		// One long frame reaches the largest positions of the run: 255 blank
		// rows at full width, then a string of large skips and a few runs
		// more. A zero followed by the end marker first brings the decoder
		// back to the start of a frame whatever state the random part left
		// it in.
		gaps_on = 1'b1;
		write_width(WidthMax);
		send_byte(8'd0);
		send_byte(CodeEnd);
		send_byte(CodeEnd);
		repeat (16) begin
			send_byte(CodeSkip);
			send_byte(ByteBits'($urandom_range(230, 255)));
		end
		send_byte(8'd77);
		send_byte(CodeSkip);
		send_byte(8'd9);
		send_byte(CodeEnd);
		// The position must restart from zero after that frame.
		send_frame(8, 1'b1);

		settle();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
